>>> sv/assert_macros.svh
// Assertion helpers for the calibrator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> sv/hic_pkg.sv
`timescale 1ns / 1ps
package hic_pkg;

  // Command codes carried in the input tuser
  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Result status codes carried in the output tuser
  localparam logic [1:0] STATUS_RUNNING = 2'd0;
  localparam logic [1:0] STATUS_PASSED  = 2'd1;
  localparam logic [1:0] STATUS_FAILED  = 2'd2;

  // Offset byte layouts
  localparam logic LAYOUT_LITTLE  = 1'b0;
  localparam logic LAYOUT_SHIFTED = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_SAMPLE_LIMIT   = 2'd0;
  localparam logic [1:0] REG_SPAN_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_BYTE_LAYOUT    = 2'd2;

  // Register reset values
  localparam logic [15:0] SAMPLE_LIMIT_RESET   = 16'd300;
  localparam logic [15:0] SPAN_THRESHOLD_RESET = 16'd100;

  // Bounds loaded at the start of a run
  localparam logic signed [15:0] START_MIN = 16'sd32765;
  localparam logic signed [15:0] START_MAX = -16'sd32765;

  // Byte masks of the shifted layout
  localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;
  localparam logic [15:0] LOW_EVEN_MASK  = 16'h00FE;

  // Result payload, first field in the lowest bits
  typedef struct packed {
    logic [7:0]  reg_byte_5;
    logic [7:0]  reg_byte_4;
    logic [7:0]  reg_byte_3;
    logic [7:0]  reg_byte_2;
    logic [7:0]  reg_byte_1;
    logic [7:0]  reg_byte_0;
    logic [15:0] center_z;
    logic [15:0] center_y;
    logic [15:0] center_x;
  } payload_t;

  typedef struct packed {
    logic [1:0] status;
    payload_t   payload;
  } result_t;

endpackage

>>> sv/hic_axis.sv
`timescale 1ns / 1ps
module hic_axis import hic_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int ACC_BITS    = 16
) (
  input  logic                       start,
  input  logic                       hold,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [ACC_BITS-1:0] cur_min,
  input  logic signed [ACC_BITS-1:0] cur_max,
  input  logic [15:0]                threshold,
  output logic signed [ACC_BITS-1:0] min_next,
  output logic signed [ACC_BITS-1:0] max_next,
  output logic                       wide,
  output logic [15:0]                center
);

  logic signed [ACC_BITS-1:0] smp;
  logic signed [ACC_BITS-1:0] upd_min;
  logic signed [ACC_BITS-1:0] upd_max;
  logic signed [ACC_BITS:0]   diff;
  logic [ACC_BITS:0]          span_abs;
  logic signed [ACC_BITS:0]   sum;
  logic signed [ACC_BITS:0]   rounded;
  logic signed [ACC_BITS:0]   half;

  // Widen the sample and fold it into the bounds
  assign smp     = ACC_BITS'(sample);
  assign upd_min = (cur_min > smp) ? smp : cur_min;
  assign upd_max = (cur_max < smp) ? smp : cur_max;

  // Span of the updated bounds against the threshold
  assign diff     = (ACC_BITS+1)'(upd_max) - (ACC_BITS+1)'(upd_min);
  assign span_abs = diff[ACC_BITS] ? $unsigned(-diff) : $unsigned(diff);
  assign wide     = span_abs > (ACC_BITS+1)'(threshold);

  // Restart, hold or take the updated bounds
  always_comb begin
    priority if (start) begin
      min_next = ACC_BITS'(START_MIN);
      max_next = ACC_BITS'(START_MAX);
    end else if (hold) begin
      min_next = cur_min;
      max_next = cur_max;
    end else begin
      min_next = upd_min;
      max_next = upd_max;
    end
  end

  // Midpoint, truncated toward zero
  assign sum     = (ACC_BITS+1)'(max_next) + (ACC_BITS+1)'(min_next);
  assign rounded = sum + {{ACC_BITS{1'b0}}, sum[ACC_BITS]};
  assign half    = rounded >>> 1;
  assign center  = half[15:0];

endmodule

>>> sv/hic_pack.sv
`timescale 1ns / 1ps
module hic_pack import hic_pkg::*; (
  input  logic [1:0]  status,
  input  logic        passed,
  input  logic        layout,
  input  logic [15:0] center_x,
  input  logic [15:0] center_y,
  input  logic [15:0] center_z,
  output result_t     result
);

  logic [15:0] cx;
  logic [15:0] cy;
  logic [15:0] cz;
  logic [15:0] sx;
  logic [15:0] sy;
  logic [15:0] sz;

  // Zero the offsets unless the run passed
  assign cx = passed ? center_x : '0;
  assign cy = passed ? center_y : '0;
  assign cz = passed ? center_z : '0;

  // Doubled offsets, wrapped to 16 bits
  assign sx = {cx[14:0], 1'b0};
  assign sy = {cy[14:0], 1'b0};
  assign sz = {cz[14:0], 1'b0};

  // Lay out the offset bytes
  always_comb begin
    result.status           = status;
    result.payload.center_x = cx;
    result.payload.center_y = cy;
    result.payload.center_z = cz;
    unique case (layout)
      LAYOUT_SHIFTED: begin
        result.payload.reg_byte_0 = 8'((sx & HIGH_BYTE_MASK) >> 8);
        result.payload.reg_byte_1 = 8'(sx & LOW_EVEN_MASK);
        result.payload.reg_byte_2 = 8'((sy & HIGH_BYTE_MASK) >> 8);
        result.payload.reg_byte_3 = 8'(sy & LOW_EVEN_MASK);
        result.payload.reg_byte_4 = 8'((sz & HIGH_BYTE_MASK) >> 8);
        result.payload.reg_byte_5 = 8'(sz & LOW_EVEN_MASK);
      end
      default: begin
        result.payload.reg_byte_0 = cx[7:0];
        result.payload.reg_byte_1 = cx[15:8];
        result.payload.reg_byte_2 = cy[7:0];
        result.payload.reg_byte_3 = cy[15:8];
        result.payload.reg_byte_4 = cz[7:0];
        result.payload.reg_byte_5 = cz[15:8];
      end
    endcase
  end

endmodule

>>> sv/hic_outbuf.sv
`timescale 1ns / 1ps
module hic_outbuf import hic_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    in_fire;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payloads along
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

>>> sv/magnetometer_hard_iron_calibrator.sv
// Hard-iron calibrator for a three-axis magnetometer by the min/max method. An item with
// tuser 0 starts a new run; an item with tuser 1 carries one sample (x, y, z from the low
// bits of tdata up) and folds it into per-axis minimum and maximum. The run passes once
// every axis span exceeds span_threshold and the zero-based sample index exceeds
// sample_limit/2; it fails when sample_limit samples arrive without a pass. Every item
// gives one result: status in tuser and, when passed, the per-axis offsets (max+min)/2 and
// the six offset register bytes in tdata. Samples after the run ended leave the state alone.
// One item is taken per cycle while the skid buffer is empty; the min/max update, pass
// test and offset calculation sit between the state registers and the registered output,
// which is backed by a one-entry skid buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module magnetometer_hard_iron_calibrator import hic_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // samples in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: mag_x, mag_y, mag_z, zero fill
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: cmd
  input  logic        s_axis_tuser,
  // results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: center_x, center_y, center_z, reg_byte_0 .. reg_byte_5
  output logic [95:0] m_axis_tdata,
  // tuser: status
  output logic [1:0]  m_axis_tuser
);

  localparam int ACC_BITS = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  logic [15:0] sample_limit;
  logic [15:0] span_threshold;
  logic        byte_layout;
  logic        cfg_write;

  logic [15:0]                sample_index;
  logic signed [ACC_BITS-1:0] axis_min [3];
  logic signed [ACC_BITS-1:0] axis_max [3];
  logic                       run_finished;
  logic                       run_passed;

  logic [15:0]                sample_index_next;
  logic signed [ACC_BITS-1:0] axis_min_next [3];
  logic signed [ACC_BITS-1:0] axis_max_next [3];
  logic                       run_finished_next;
  logic                       run_passed_next;

  logic signed [SAMPLE_BITS-1:0] mag [3];
  logic [2:0]                    axis_wide;
  logic [15:0]                   center [3];
  logic                          start;
  logic                          in_fire;
  logic [16:0]                   index_inc;
  logic [1:0]                    status_next;
  result_t                       result_next;
  result_t                       result_out;

  logic                          out_not_passed;
  logic                          start_fire;
  logic                          run_clear;
  logic                          run_kept;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_limit   <= SAMPLE_LIMIT_RESET;
      span_threshold <= SPAN_THRESHOLD_RESET;
      byte_layout    <= LAYOUT_LITTLE;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_SAMPLE_LIMIT:   sample_limit   <= pwdata[15:0];
        REG_SPAN_THRESHOLD: span_threshold <= pwdata[15:0];
        REG_BYTE_LAYOUT:    byte_layout    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SAMPLE_LIMIT:   prdata = {16'd0, sample_limit};
      REG_SPAN_THRESHOLD: prdata = {16'd0, span_threshold};
      REG_BYTE_LAYOUT:    prdata = {31'd0, byte_layout};
      default:            prdata = '0;
    endcase
  end

  // Unpack the input item
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign start   = (s_axis_tuser == CMD_START);
  assign mag[0]  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign mag[1]  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign mag[2]  = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

  // Per-axis bound update
  for (genvar k = 0; k < 3; k++) begin : g_axis
    hic_axis #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .ACC_BITS   (ACC_BITS)
    ) u_axis (
      .start    (start),
      .hold     (run_finished),
      .sample   (mag[k]),
      .cur_min  (axis_min[k]),
      .cur_max  (axis_max[k]),
      .threshold(span_threshold),
      .min_next (axis_min_next[k]),
      .max_next (axis_max_next[k]),
      .wide     (axis_wide[k]),
      .center   (center[k])
    );
  end

  // Pass and fail decision
  assign index_inc = {1'b0, sample_index} + 17'd1;

  always_comb begin
    sample_index_next = sample_index;
    run_finished_next = run_finished;
    run_passed_next   = run_passed;
    priority if (start) begin
      sample_index_next = '0;
      run_finished_next = 1'b0;
      run_passed_next   = 1'b0;
    end else if (!run_finished) begin
      priority if ((&axis_wide) && (sample_index > (sample_limit >> 1))) begin
        run_finished_next = 1'b1;
        run_passed_next   = 1'b1;
      end else if (index_inc >= {1'b0, sample_limit}) begin
        run_finished_next = 1'b1;
      end else begin
        sample_index_next = index_inc[15:0];
      end
    end else begin
      // Ended run: hold everything
    end
  end

  // Advance the run state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      run_finished <= 1'b0;
      run_passed   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        axis_min[k] <= ACC_BITS'(START_MIN);
        axis_max[k] <= ACC_BITS'(START_MAX);
      end
    end else if (in_fire) begin
      sample_index <= sample_index_next;
      run_finished <= run_finished_next;
      run_passed   <= run_passed_next;
      for (int k = 0; k < 3; k++) begin
        axis_min[k] <= axis_min_next[k];
        axis_max[k] <= axis_max_next[k];
      end
    end
  end

  // Build the result item
  assign status_next = !run_finished_next ? STATUS_RUNNING :
                       run_passed_next    ? STATUS_PASSED  : STATUS_FAILED;

  hic_pack u_pack (
    .status  (status_next),
    .passed  (run_passed_next),
    .layout  (byte_layout),
    .center_x(center[0]),
    .center_y(center[1]),
    .center_z(center[2]),
    .result  (result_next)
  );

  hic_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (result_next),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (result_out)
  );

  assign m_axis_tdata = result_out.payload;
  assign m_axis_tuser = result_out.status;

  // Checks
  assign out_not_passed = m_axis_tvalid && (m_axis_tuser != STATUS_PASSED);
  assign start_fire     = in_fire && start;
  assign run_clear      = (sample_index == '0) && !run_finished;
  assign run_kept       = run_finished && !start_fire;

  `ASSERT_ON_CLK(a_pass_ends_run, run_passed |-> run_finished, "passed run not finished")
  `ASSERT_ON_CLK(a_offsets_need_pass, out_not_passed |-> m_axis_tdata == '0, "offsets but no pass")
  `ASSERT_NEXT(a_start_clears, start_fire, run_clear, "start did not clear the run")
  `ASSERT_NEXT(a_finished_holds, run_kept, $stable(sample_index) && run_finished, "ended run moved")

endmodule
